@@ rtl/dsec_pkg.sv @@
// Shared constants and calendar tables for the decimal stamp to epoch seconds core.
`default_nettype none

package dsec_pkg;

   // Reciprocals for division by a constant: floor(n * M / 2^k) equals floor(n / d)
   // over the full input range of each divider stage.
   // ceil(2^60 / 10^6), valid for 40-bit dividends.
   localparam logic [40:0] RECIP_1E6 = 41'd1152921504607;
   localparam int          RECIP_1E6_SHIFT = 60;
   // ceil(2^34 / 10^4), valid for 20-bit dividends.
   localparam logic [20:0] RECIP_1E4 = 21'd1717987;
   localparam int          RECIP_1E4_SHIFT = 34;
   // ceil(2^21 / 100), valid for 14-bit dividends.
   localparam logic [14:0] RECIP_100 = 15'd20972;
   localparam int          RECIP_100_SHIFT = 21;

   localparam logic [19:0] MILLION      = 20'd1000000;
   localparam logic [13:0] TEN_THOUSAND = 14'd10000;
   localparam logic [6:0]  HUNDRED      = 7'd100;

   localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
   localparam logic [15:0] DAYS_1970_TO_2000 = 16'd10957;
   localparam logic [15:0] DAYS_PER_YEAR     = 16'd365;
   localparam logic [18:0] SECS_PER_HOUR     = 19'd3600;
   localparam logic [18:0] SECS_PER_MINUTE   = 19'd60;

   // Days in a common year before the first of the given month (1..12).
   function automatic logic [8:0] days_before_month(input logic [6:0] mon);
      logic [8:0] days;
      case (mon)
         7'd1:    days = 9'd0;
         7'd2:    days = 9'd31;
         7'd3:    days = 9'd59;
         7'd4:    days = 9'd90;
         7'd5:    days = 9'd120;
         7'd6:    days = 9'd151;
         7'd7:    days = 9'd181;
         7'd8:    days = 9'd212;
         7'd9:    days = 9'd243;
         7'd10:   days = 9'd273;
         7'd11:   days = 9'd304;
         7'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Length of the given month; an invalid month reads as zero days.
   function automatic logic [4:0] month_days(input logic [6:0] mon, input logic leap);
      logic [4:0] days;
      case (mon) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                     days = 5'd30;
         7'd2:                                        days = leap ? 5'd29 : 5'd28;
         default:                                     days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

@@ rtl/decimal_stamp_to_epoch_seconds_core.sv @@
// Top level: ten-stage pipeline converting a decimal YYMMDDHHMMSS stamp to Unix seconds.
//
//   Channel | Direction | tdata                       | tuser
//   --------+-----------+-----------------------------+-------------------
//   req_    | in        | [39:0] stamp                | [0] short_form
//   rsp_    | out       | [31:0] epoch_seconds        | [0] date_invalid
//
// One stamp enters per cycle while the output is not stalled; each result passes through stages 0 to 9.
// The depth is set by the chain of constant-reciprocal multipliers that split the
// stamp into base-100 digits, followed by the day count and the seconds multiply.
// Reset clears only the stage valid bits; it takes effect at the next clock edge.
// Each stage holds while the one after it is full and stalled, so bubbles are
// squeezed out and a new stamp is taken whenever the first stage can move.
`default_nettype none

module decimal_stamp_to_epoch_seconds_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [39:0] stamp
   input  logic        req_tuser,   // [0] short_form
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tuser    // [0] date_invalid
);

   localparam int NUM_STAGES = 10;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   // A stage may load when it is empty or when the stage after it loads too.
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];

   // Stage 0: partial products of stamp times the reciprocal of one million.
   logic [39:0] s0_pp_ll_ff;
   logic [40:0] s0_pp_lh_ff;
   logic [39:0] s0_pp_hl_ff;
   logic [40:0] s0_pp_hh_ff;
   logic [19:0] s0_vlo_ff;
   logic        s0_short_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_pp_ll_ff <= req_tdata[19:0]  * dsec_pkg::RECIP_1E6[19:0];
         s0_pp_lh_ff <= req_tdata[19:0]  * dsec_pkg::RECIP_1E6[40:20];
         s0_pp_hl_ff <= req_tdata[39:20] * dsec_pkg::RECIP_1E6[19:0];
         s0_pp_hh_ff <= req_tdata[39:20] * dsec_pkg::RECIP_1E6[40:20];
         s0_vlo_ff   <= req_tdata[19:0];
         s0_short_ff <= req_tuser;
      end
   end

   // Stage 1: sum the partial products; the top bits are the stamp divided by 10^6.
   logic [80:0] s1_sum;
   logic [20:0] s1_q_in;
   logic [20:0] s1_q_ff;
   logic [19:0] s1_vlo_ff;
   logic        s1_short_ff;

   assign s1_sum = {41'd0, s0_pp_ll_ff}
                 + ({40'd0, s0_pp_lh_ff} << 20)
                 + ({41'd0, s0_pp_hl_ff} << 20)
                 + ({40'd0, s0_pp_hh_ff} << 40);
   assign s1_q_in = s1_sum[80:dsec_pkg::RECIP_1E6_SHIFT];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_q_ff     <= s1_q_in;
         s1_vlo_ff   <= s0_vlo_ff;
         s1_short_ff <= s0_short_ff;
      end
   end

   // Stage 2: remainder gives HHMMSS (or YYMMDD in short form); quotient mod 10^6 gives YYMMDD.
   logic [40:0] s2_prod;
   logic [19:0] s2_rem;
   logic [19:0] s2_qmod;
   logic [19:0] s2_date_in;
   logic [19:0] s2_time_in;
   logic [19:0] s2_date_ff;
   logic [19:0] s2_time_ff;

   assign s2_prod = s1_q_ff * dsec_pkg::MILLION;
   // The remainder is below 10^6, so the low 20 bits of the difference are exact.
   assign s2_rem  = s1_vlo_ff - s2_prod[19:0];
   assign s2_qmod = (s1_q_ff >= {1'b0, dsec_pkg::MILLION})
                  ? 20'(s1_q_ff - {1'b0, dsec_pkg::MILLION}) : s1_q_ff[19:0];
   assign s2_date_in = s1_short_ff ? s2_rem : s2_qmod;
   assign s2_time_in = s1_short_ff ? 20'd0 : s2_rem;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_date_ff <= s2_date_in;
         s2_time_ff <= s2_time_in;
      end
   end

   // Stage 3: multiply both six-digit values by the reciprocal of 10^4.
   logic [40:0] s3_pd_ff;
   logic [40:0] s3_pt_ff;
   logic [19:0] s3_date_ff;
   logic [19:0] s3_time_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_pd_ff   <= s2_date_ff * dsec_pkg::RECIP_1E4;
         s3_pt_ff   <= s2_time_ff * dsec_pkg::RECIP_1E4;
         s3_date_ff <= s2_date_ff;
         s3_time_ff <= s2_time_ff;
      end
   end

   // Stage 4: top pair (YY or HH) and the four-digit remainder.
   logic [6:0]  s4_yy_in;
   logic [6:0]  s4_hh_in;
   logic [20:0] s4_dmul;
   logic [20:0] s4_tmul;
   logic [13:0] s4_drem_in;
   logic [13:0] s4_trem_in;
   logic [6:0]  s4_yy_ff;
   logic [6:0]  s4_hh_ff;
   logic [13:0] s4_drem_ff;
   logic [13:0] s4_trem_ff;

   assign s4_yy_in   = s3_pd_ff[dsec_pkg::RECIP_1E4_SHIFT+6:dsec_pkg::RECIP_1E4_SHIFT];
   assign s4_hh_in   = s3_pt_ff[dsec_pkg::RECIP_1E4_SHIFT+6:dsec_pkg::RECIP_1E4_SHIFT];
   assign s4_dmul    = s4_yy_in * dsec_pkg::TEN_THOUSAND;
   assign s4_tmul    = s4_hh_in * dsec_pkg::TEN_THOUSAND;
   assign s4_drem_in = s3_date_ff[13:0] - s4_dmul[13:0];
   assign s4_trem_in = s3_time_ff[13:0] - s4_tmul[13:0];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_yy_ff   <= s4_yy_in;
         s4_hh_ff   <= s4_hh_in;
         s4_drem_ff <= s4_drem_in;
         s4_trem_ff <= s4_trem_in;
      end
   end

   // Stage 5: multiply the four-digit remainders by the reciprocal of 100.
   logic [28:0] s5_pd_ff;
   logic [28:0] s5_pt_ff;
   logic [6:0]  s5_yy_ff;
   logic [6:0]  s5_hh_ff;
   logic [13:0] s5_drem_ff;
   logic [13:0] s5_trem_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_pd_ff   <= s4_drem_ff * dsec_pkg::RECIP_100;
         s5_pt_ff   <= s4_trem_ff * dsec_pkg::RECIP_100;
         s5_yy_ff   <= s4_yy_ff;
         s5_hh_ff   <= s4_hh_ff;
         s5_drem_ff <= s4_drem_ff;
         s5_trem_ff <= s4_trem_ff;
      end
   end

   // Stage 6: the last two pairs of each half.
   logic [6:0]  s6_mon_in;
   logic [6:0]  s6_min_in;
   logic [13:0] s6_dmul;
   logic [13:0] s6_tmul;
   logic [6:0]  s6_yy_ff;
   logic [6:0]  s6_mon_ff;
   logic [6:0]  s6_day_ff;
   logic [6:0]  s6_hh_ff;
   logic [6:0]  s6_min_ff;
   logic [6:0]  s6_sec_ff;

   assign s6_mon_in = s5_pd_ff[dsec_pkg::RECIP_100_SHIFT+6:dsec_pkg::RECIP_100_SHIFT];
   assign s6_min_in = s5_pt_ff[dsec_pkg::RECIP_100_SHIFT+6:dsec_pkg::RECIP_100_SHIFT];
   assign s6_dmul   = s6_mon_in * dsec_pkg::HUNDRED;
   assign s6_tmul   = s6_min_in * dsec_pkg::HUNDRED;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_yy_ff  <= s5_yy_ff;
         s6_mon_ff <= s6_mon_in;
         s6_day_ff <= s5_drem_ff[6:0] - s6_dmul[6:0];
         s6_hh_ff  <= s5_hh_ff;
         s6_min_ff <= s6_min_in;
         s6_sec_ff <= s5_trem_ff[6:0] - s6_tmul[6:0];
      end
   end

   // Stage 7: date check, day count since 1970 and seconds within the day.
   logic        s7_leap;
   logic [4:0]  s7_dim;
   logic        s7_invalid_in;
   logic [6:0]  s7_leaps_before;
   logic [15:0] s7_days_in;
   logic [18:0] s7_tsec_in;
   logic [15:0] s7_days_ff;
   logic [18:0] s7_tsec_ff;
   logic        s7_invalid_ff;

   // Years 2000..2099 are leap exactly when divisible by four.
   assign s7_leap = (s6_yy_ff[1:0] == 2'd0);
   assign s7_dim  = dsec_pkg::month_days(s6_mon_ff, s7_leap);
   assign s7_invalid_in = (s6_mon_ff < 7'd1) || (s6_mon_ff > 7'd12)
                       || (s6_day_ff < 7'd1) || (s6_day_ff > {2'd0, s7_dim});
   assign s7_leaps_before = 7'(({1'b0, s6_yy_ff} + 8'd3) >> 2);
   assign s7_days_in = dsec_pkg::DAYS_1970_TO_2000
                     + 16'({9'd0, s6_yy_ff} * dsec_pkg::DAYS_PER_YEAR)
                     + {9'd0, s7_leaps_before}
                     + {7'd0, dsec_pkg::days_before_month(s6_mon_ff)}
                     + {15'd0, ((s6_mon_ff > 7'd2) && s7_leap)}
                     + {9'd0, s6_day_ff} - 16'd1;
   assign s7_tsec_in = 19'({12'd0, s6_hh_ff} * dsec_pkg::SECS_PER_HOUR)
                     + 19'({12'd0, s6_min_ff} * dsec_pkg::SECS_PER_MINUTE)
                     + {12'd0, s6_sec_ff};

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_days_ff    <= s7_days_in;
         s7_tsec_ff    <= s7_tsec_in;
         s7_invalid_ff <= s7_invalid_in;
      end
   end

   // Stage 8: whole days to seconds.
   logic [32:0] s8_dsec_ff;
   logic [18:0] s8_tsec_ff;
   logic        s8_invalid_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_dsec_ff    <= s7_days_ff * dsec_pkg::SECS_PER_DAY;
         s8_tsec_ff    <= s7_tsec_ff;
         s8_invalid_ff <= s7_invalid_ff;
      end
   end

   // Stage 9: output register.
   logic [31:0] s9_secs_in;
   logic [31:0] s9_secs_ff;
   logic        s9_invalid_ff;

   assign s9_secs_in = s8_invalid_ff ? 32'd0 : (s8_dsec_ff[31:0] + {13'd0, s8_tsec_ff});

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s9_secs_ff    <= s9_secs_in;
         s9_invalid_ff <= s8_invalid_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = s9_secs_ff;
   assign rsp_tuser  = s9_invalid_ff;

endmodule

`default_nettype wire

@@ rtl/dsec_checker.sv @@
// Port-level checks for the decimal stamp to epoch seconds core, with its bind.
`default_nettype none

module dsec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser
);

   // Reset empties the pipeline, so no result shows in the next cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its value until the transaction completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // A rejected date always carries zero seconds.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 32'd0))
      else $error("invalid date with nonzero seconds");

   // Seconds never pass the value for 2099-12-31 plus 99:99:99.
   a_secs_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= 32'd4102720839))
      else $error("seconds out of range");

   // With no result pending every stage can move, so a stamp is always taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind decimal_stamp_to_epoch_seconds_core dsec_checker u_dsec_checker (.*);

`default_nettype wire
